### rtl/core/astm_pkg.sv
// Package for the accel step and motion tracker.
// Holds shared constants and register indexes; no dependencies.
package astm_pkg;
  localparam int unsigned Window = 196;
  localparam logic [2:0] REG_HIGH  = 3'd0;
  localparam logic [2:0] REG_LOW   = 3'd1;
  localparam logic [2:0] REG_NOISE = 3'd2;
  localparam logic [2:0] REG_REST  = 3'd3;
  localparam logic [2:0] REG_STILL = 3'd4;
  localparam logic [2:0] REG_GAIN  = 3'd5;
  localparam logic [2:0] REG_PER   = 3'd6;
  localparam logic [7:0] WIN_LAST  = 8'(Window - 1);
endpackage

### rtl/core/astm_mul.sv
// Bit-serial shift-and-add multiplier: unsigned a times signed or unsigned b.
// One multiplier bit per cycle; depends on nothing else.
module astm_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic        [40:0] a,
  input  logic signed [40:0] b,
  output logic               done,
  output logic signed [82:0] prod
);
  logic [40:0] mcand;
  logic [5:0]  cnt;
  logic        busy;
  logic signed [82:0] bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        mcand <= a;
        bsh   <= 83'(b);
        prod  <= '0;
        cnt   <= '0;
      end else if (busy) begin
        if (mcand[0]) prod <= prod + bsh;
        mcand <= mcand >> 1;
        bsh   <= bsh <<< 1;
        cnt   <= cnt + 6'd1;
        if (cnt == 6'd40) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/core/astm_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on nothing else.
module astm_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] n,
  output logic        done,
  output logic [16:0] root
);
  logic [35:0] rem;
  logic [33:0] src;
  logic [4:0]  cnt;
  logic        busy;
  logic [35:0] trial;

  assign trial = {rem[33:0], src[33:32]} - {17'd0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        root <= '0;
        src  <= n;
        cnt  <= '0;
      end else if (busy) begin
        if (!trial[35]) begin
          rem  <= trial;
          root <= {root[15:0], 1'b1};
        end else begin
          rem  <= {rem[33:0], src[33:32]};
          root <= {root[15:0], 1'b0};
        end
        src <= src << 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/core/astm_div.sv
// Restoring divider of a signed 24-bit sum by the window length, one bit a cycle.
// Uses astm_pkg.
module astm_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [23:0] num,
  output logic               done,
  output logic signed [15:0] quot
);
  logic [23:0] q;
  logic [8:0]  rem;
  logic        neg;
  logic [4:0]  cnt;
  logic        busy;
  logic [8:0]  sh;

  assign sh = {rem[7:0], q[23]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= num[23];
        q    <= num[23] ? -num : num;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (sh >= 9'(astm_pkg::Window)) begin
          rem <= sh - 9'(astm_pkg::Window);
          q   <= {q[22:0], 1'b1};
        end else begin
          rem <= sh;
          q   <= {q[22:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -q[15:0] : q[15:0];
endmodule

### rtl/core/accel_step_and_motion_tracker.sv
// Top level of the accel step and motion tracker: sequencer and state.
// Uses astm_pkg, astm_mul, astm_sqrt, astm_div.
//
// Usage: one sample enters on the in channel (in_valid/in_stall) and
// one result item leaves on the out channel (out_valid/out_stall).
// Items are worked one at a time. Each item takes seven passes through
// one bit-serial multiplier (three squarings, speed gain, distance,
// north and east heading products) and a square root. Window averages
// take three passes through a serial divider that runs alongside; the
// east pass does not finish until the averages are done.
// in_stall is high from acceptance until the result is taken from the
// output register; a new sample may be accepted in the cycle the result
// is taken. Synchronous reset (rst high) clears the sequencer, counters,
// sums, averages and outputs and restores the register defaults;
// no clearing pass is needed. While out_stall is high the result holds
// and no sample is accepted.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it while idle, not enforced here.
module accel_step_and_motion_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] heading_cos,
  input  logic signed [15:0] heading_sin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        step_count,
  output logic [30:0]        velocity,
  output logic [39:0]        distance,
  output logic signed [39:0] disp_north,
  output logic signed [39:0] disp_east,
  output logic signed [15:0] avg_x,
  output logic signed [15:0] avg_y,
  output logic signed [15:0] avg_z,
  output logic               avg_valid
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_SQZ  = 4'd3;
  localparam logic [3:0] S_RT   = 4'd4;
  localparam logic [3:0] S_DV   = 4'd5;
  localparam logic [3:0] S_DS   = 4'd6;
  localparam logic [3:0] S_N    = 4'd7;
  localparam logic [3:0] S_E    = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [31:0] step_high_sq, step_low_sq;
  logic [14:0] noise_threshold;
  logic [15:0] rest_magnitude, velocity_gain, sample_period;
  logic [7:0]  still_limit;

  logic [3:0]  state;
  logic signed [15:0] sx, sy, sz, hc, hs;
  logic [7:0]  window_count, quiet_count;
  logic signed [23:0] sum_x, sum_y, sum_z;
  logic        step_armed, win_done;
  logic [15:0] steps_total;
  logic [30:0] speed;
  logic [39:0] path_length;
  logic signed [39:0] north_pos, east_pos;
  logic [33:0] m2;
  logic [16:0] excess;
  logic [31:0] ds;
  logic [1:0]  div_sel;

  logic        mul_start, mul_done;
  logic [40:0] mul_a;
  logic signed [40:0] mul_b;
  logic signed [82:0] prod;
  logic        rt_start, rt_done;
  logic [16:0] root;
  logic        dv_start, dv_done;
  logic signed [23:0] dv_num;
  logic signed [15:0] quot;

  logic signed [17:0] exc_s;
  logic [31:0] spd_sum;
  logic [40:0] path_sum;
  logic signed [41:0] pos_sum;
  logic signed [39:0] pos_cur;
  logic signed [39:0] pos_new;
  logic [33:0] m2_fin;
  logic        quiet;
  logic [8:0]  nq;

  astm_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                  .done(mul_done), .prod);
  astm_sqrt u_sqrt (.clk, .rst, .start(rt_start), .n(m2), .done(rt_done), .root);
  astm_div u_div (.clk, .rst, .start(dv_start), .num(dv_num), .done(dv_done), .quot);

  assign in_stall = (state != S_IDLE) && !(state == S_OUT && !out_stall);
  assign out_valid = (state == S_OUT);
  assign step_count = steps_total;
  assign velocity = speed;
  assign distance = path_length;
  assign disp_north = north_pos;
  assign disp_east = east_pos;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin mul_a = 41'(sx[15] ? -17'(sx) : 17'(sx)); mul_b = 41'(sx[15] ? -17'(sx) : 17'(sx)); end
      S_SQY: begin mul_a = 41'(sy[15] ? -17'(sy) : 17'(sy)); mul_b = 41'(sy[15] ? -17'(sy) : 17'(sy)); end
      S_SQZ: begin mul_a = 41'(sz[15] ? -17'(sz) : 17'(sz)); mul_b = 41'(sz[15] ? -17'(sz) : 17'(sz)); end
      S_DV:  begin mul_a = 41'(excess); mul_b = 41'(velocity_gain); end
      S_DS:  begin mul_a = 41'(speed); mul_b = 41'(sample_period); end
      S_N:   begin mul_a = 41'(ds); mul_b = 41'(hc); end
      S_E:   begin mul_a = 41'(ds); mul_b = 41'(hs); end
      default: ;
    endcase
  end

  assign m2_fin = m2 + 34'(prod);
  assign exc_s = $signed({1'b0, root}) - $signed({2'b0, rest_magnitude});
  assign quiet = exc_s < $signed({3'b0, noise_threshold});
  assign nq = {1'b0, quiet_count} + 9'd1;
  assign spd_sum = {1'b0, speed} + 32'(prod >>> 14);
  assign path_sum = {1'b0, path_length} + 41'(ds);
  assign pos_cur = (state == S_N) ? north_pos : east_pos;
  assign pos_sum = 42'(pos_cur) + 42'(prod >>> 14);
  assign pos_new = (pos_sum > 42'sh7FFFFFFFFF) ? 40'sh7FFFFFFFFF :
                   (pos_sum < -42'sh8000000000) ? -40'sh8000000000 : pos_sum[39:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_high_sq <= 32'd362387865;
      step_low_sq <= 32'd241591910;
      noise_threshold <= 15'd328;
      rest_magnitude <= 16'd16384;
      still_limit <= 8'd25;
      velocity_gain <= 16'd32883;
      sample_period <= 16'd3355;
    end else if (cfg_we) begin
      case (cfg_index)
        astm_pkg::REG_HIGH:  step_high_sq <= cfg_data;
        astm_pkg::REG_LOW:   step_low_sq <= cfg_data;
        astm_pkg::REG_NOISE: noise_threshold <= cfg_data[14:0];
        astm_pkg::REG_REST:  rest_magnitude <= cfg_data[15:0];
        astm_pkg::REG_STILL: still_limit <= cfg_data[7:0];
        astm_pkg::REG_GAIN:  velocity_gain <= cfg_data[15:0];
        astm_pkg::REG_PER:   sample_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window_count <= '0;
      sum_x <= '0; sum_y <= '0; sum_z <= '0;
      avg_x <= '0; avg_y <= '0; avg_z <= '0;
      step_armed <= 1'b0; steps_total <= '0; quiet_count <= '0;
      speed <= '0; path_length <= '0; north_pos <= '0; east_pos <= '0;
      mul_start <= 1'b0; rt_start <= 1'b0; dv_start <= 1'b0;
      div_sel <= '0; win_done <= 1'b0; avg_valid <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      rt_start <= 1'b0;
      dv_start <= 1'b0;
      if (dv_done) begin
        case (div_sel)
          2'd0: begin avg_x <= quot; dv_num <= sum_y; dv_start <= 1'b1; div_sel <= 2'd1; end
          2'd1: begin avg_y <= quot; dv_num <= sum_z; dv_start <= 1'b1; div_sel <= 2'd2; end
          default: begin
            avg_z <= quot;
            sum_x <= '0; sum_y <= '0; sum_z <= '0;
            win_done <= 1'b0;
          end
        endcase
      end
      case (state)
        S_IDLE, S_OUT: begin
          if (state == S_OUT && !out_stall) state <= S_IDLE;
          if (in_valid && !in_stall) begin
            sx <= accel_x; sy <= accel_y; sz <= accel_z;
            hc <= heading_cos; hs <= heading_sin;
            m2 <= '0;
            mul_start <= 1'b1;
            state <= S_SQX;
            if (window_count == astm_pkg::WIN_LAST) begin
              window_count <= '0;
              dv_num <= sum_x + 24'(accel_x);
              sum_y <= sum_y + 24'(accel_y);
              sum_z <= sum_z + 24'(accel_z);
              dv_start <= 1'b1;
              div_sel <= 2'd0;
              win_done <= 1'b1;
            end else begin
              window_count <= window_count + 8'd1;
              sum_x <= sum_x + 24'(accel_x);
              sum_y <= sum_y + 24'(accel_y);
              sum_z <= sum_z + 24'(accel_z);
            end
            avg_valid <= (window_count == astm_pkg::WIN_LAST);
          end
        end
        S_SQX, S_SQY: if (mul_done) begin
          m2 <= m2_fin;
          mul_start <= 1'b1;
          state <= state + 4'd1;
        end
        S_SQZ: if (mul_done) begin
          m2 <= m2_fin;
          rt_start <= 1'b1;
          if (m2_fin >= 34'(step_high_sq) || step_armed) begin
            if (m2_fin <= 34'(step_low_sq)) begin
              step_armed <= 1'b0;
              if (steps_total != 16'hFFFF) steps_total <= steps_total + 16'd1;
            end else step_armed <= 1'b1;
          end
          state <= S_RT;
        end
        S_RT: if (rt_done) begin
          if (quiet) begin
            excess <= '0;
            if (nq > {1'b0, still_limit}) begin
              speed <= '0;
              quiet_count <= '0;
            end else quiet_count <= nq[7:0];
          end else excess <= exc_s[16:0];
          mul_start <= 1'b1;
          state <= S_DV;
        end
        S_DV: if (mul_done) begin
          speed <= spd_sum[31] ? 31'h7FFFFFFF : spd_sum[30:0];
          mul_start <= 1'b1;
          state <= S_DS;
        end
        S_DS: if (mul_done) begin
          ds <= 32'(prod >>> 16);
          state <= S_N;
          mul_start <= 1'b1;
        end
        S_N: if (mul_done) begin
          path_length <= path_sum[40] ? 40'hFFFFFFFFFF : path_sum[39:0];
          north_pos <= pos_new;
          mul_start <= 1'b1;
          state <= S_E;
        end
        S_E: if (mul_done && !win_done) begin
          east_pos <= pos_new;
          state <= S_OUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
